### hdl/lic_pkg.sv
// Shared types, constants and digit helpers for the Luhn ID check block.
`timescale 1ns / 1ps
package lic_pkg;

  localparam int ID_W           = 30;
  localparam int SUM_W          = 7;
  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS_DEF = 9;

  // Reciprocal of ten for 32-bit inputs: q = (x * RECIP10) >> RECIP10_SHIFT.
  localparam int                    RECIP_W       = 32;
  localparam logic [RECIP_W-1:0]    RECIP10       = 32'hCCCC_CCCD;
  localparam int                    RECIP10_SHIFT = 35;
  localparam int                    PROD_W        = ID_W + RECIP_W;

  localparam logic [SUM_W-1:0] SUM_MAX_TENS = SUM_W'(12);

  typedef struct packed {
    logic [ID_W-1:0]  rest;  // digits not yet consumed
    logic [SUM_W-1:0] sum;   // running weighted sum
  } lic_beat_t;

  // Double a digit and fold a two-digit product into its digit sum.
  function automatic logic [DIGIT_W-1:0] luhn_fold(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] dbl;
    dbl = {d, 1'b0};
    if (dbl >= 5'd10) begin
      luhn_fold = DIGIT_W'(dbl - 5'd9);
    end else begin
      luhn_fold = dbl[DIGIT_W-1:0];
    end
  endfunction

  // True when s is a nonzero multiple of ten.
  function automatic logic is_tens(input logic [SUM_W-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int k = 1; k <= int'(SUM_MAX_TENS); k++) begin
      if (s == SUM_W'(10 * k)) begin
        hit = 1'b1;
      end
    end
    is_tens = hit;
  endfunction

endpackage

### hdl/lic_if.sv
// Valid/ready channel interfaces for the Luhn ID check block.
`timescale 1ns / 1ps
interface lic_in_if;
  logic                     valid;
  logic                     ready;
  logic [lic_pkg::ID_W-1:0] id_number;

  modport source (output valid, output id_number, input ready);
  modport sink   (input valid, input id_number, output ready);
endinterface

interface lic_out_if;
  logic                      valid;
  logic                      ready;
  logic                      is_valid;
  logic [lic_pkg::SUM_W-1:0] digit_sum;

  modport source (output valid, output is_valid, output digit_sum, input ready);
  modport sink   (input valid, input is_valid, input digit_sum, output ready);
endinterface

### hdl/lic_digit_cell.sv
// One digit cell: peels the lowest decimal digit, weights it, adds it to the sum.
`timescale 1ns / 1ps
module lic_digit_cell #(
  parameter bit DOUBLE = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  output logic               ready_in,
  input  lic_pkg::lic_beat_t beat_in,
  output logic               valid_out,
  input  logic               ready_out,
  output lic_pkg::lic_beat_t beat_out
);

  logic                               valid_r;
  lic_pkg::lic_beat_t                 beat_r;
  lic_pkg::lic_beat_t                 beat_nxt;
  logic [lic_pkg::PROD_W-1:0]         prod;
  logic [lic_pkg::ID_W-1:0]           quo;
  logic [lic_pkg::ID_W-1:0]           quo10;
  logic [lic_pkg::DIGIT_W-1:0]        digit;
  logic [lic_pkg::DIGIT_W-1:0]        weighted;

  // x / 10 by reciprocal multiply, remainder from x - 10q (low bits suffice)
  assign prod  = {{lic_pkg::RECIP_W{1'b0}}, beat_in.rest}
               * {{lic_pkg::ID_W{1'b0}}, lic_pkg::RECIP10};
  assign quo   = lic_pkg::ID_W'(prod[lic_pkg::PROD_W-1:lic_pkg::RECIP10_SHIFT]);
  assign quo10 = (quo << 3) + (quo << 1);
  assign digit = beat_in.rest[lic_pkg::DIGIT_W-1:0] - quo10[lic_pkg::DIGIT_W-1:0];

  assign weighted = DOUBLE ? lic_pkg::luhn_fold(digit) : digit;

  always_comb begin
    beat_nxt.rest = quo;
    beat_nxt.sum  = beat_in.sum + lic_pkg::SUM_W'(weighted);
  end

  assign ready_in  = !valid_r || ready_out;
  assign valid_out = valid_r;
  assign beat_out  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

### hdl/luhn_id_number_check.sv
// Top level of the Luhn mod-10 identity number checker.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : one beat per identity number (id_number, 30-bit binary value).
//   out_ch : one beat per number: digit_sum (Luhn weighted sum of the
//            NUM_DIGITS lowest decimal digits) and is_valid (sum is a
//            nonzero multiple of ten). Higher decimal digits are ignored.
// Structure: a row of NUM_DIGITS digit cells. Each cell splits off the
//   lowest remaining digit with a reciprocal-of-ten multiply, doubles and
//   folds it on odd positions, adds it to the running sum and registers the
//   shortened number and sum as the beat handed to the next cell.
// Throughput: one beat per cycle; every cell holds its own beat, so a new
//   number enters each cycle as long as the row keeps moving.
// Stall: when out_ch.ready is low the last cell holds its beat; upstream
//   cells keep filling empty slots, so in_ch.ready only drops once every
//   cell is occupied. Ready runs back through the row combinationally.
// Reset: synchronous, active low; clears all cell valid flags, so no beat
//   is presented after reset. Payload registers are not reset.
// Result ordering is strictly first in, first out.
module luhn_id_number_check #(
  parameter int NUM_DIGITS = lic_pkg::NUM_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lic_in_if.sink     in_ch,
  lic_out_if.source  out_ch
);

  // Link i feeds cell i; link NUM_DIGITS is the row's output.
  logic               link_valid [NUM_DIGITS+1];
  logic               link_ready [NUM_DIGITS+1];
  lic_pkg::lic_beat_t link_beat  [NUM_DIGITS+1];

  assign link_valid[0]     = in_ch.valid;
  assign in_ch.ready       = link_ready[0];
  assign link_beat[0].rest = in_ch.id_number;
  assign link_beat[0].sum  = '0;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    // second digit from the right, fourth, ... are doubled
    lic_digit_cell #(
      .DOUBLE ((i % 2) == 1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (link_valid[i]),
      .ready_in  (link_ready[i]),
      .beat_in   (link_beat[i]),
      .valid_out (link_valid[i+1]),
      .ready_out (link_ready[i+1]),
      .beat_out  (link_beat[i+1])
    );
  end

  assign out_ch.valid          = link_valid[NUM_DIGITS];
  assign link_ready[NUM_DIGITS] = out_ch.ready;
  assign out_ch.digit_sum      = link_beat[NUM_DIGITS].sum;
  assign out_ch.is_valid       = lic_pkg::is_tens(link_beat[NUM_DIGITS].sum);

endmodule

### tb/luhn_id_number_check_tb.sv
// Self-checking testbench for the Luhn mod-10 identity number checker.
`timescale 1ns / 1ps
module luhn_id_number_check_tb;

  localparam int ID_W          = lic_pkg::ID_W;
  localparam int SUM_W         = lic_pkg::SUM_W;
  localparam int DIGITS        = lic_pkg::NUM_DIGITS_DEF;
  localparam int STALL_LIMIT   = 5000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off, well past the row depth
  localparam int SETTLE_CYCLES = DIGITS + 20;
  localparam int MAX_REPORTS   = 10;
  localparam int IDLE_PCT      = 19;
  localparam int RANDOM_ITEMS  = 600;
  localparam int BURST_ITEMS   = 30;

  typedef struct packed {
    logic             is_valid;
    logic [SUM_W-1:0] digit_sum;
  } luhn_verdict_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    luhn_verdict_t   verdict;
  } pending_check_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lic_in_if  in_ch ();
  lic_out_if out_ch ();

  luhn_id_number_check #(.NUM_DIGITS(DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_check_t pending_q[$];
  int unsigned    n_sent       = 0;
  int unsigned    n_checked    = 0;
  int unsigned    n_passing    = 0;
  int unsigned    n_errors     = 0;
  int unsigned    hold_trigger = 0;
  bit             quiet        = 1'b0;  // no random idling on either side

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Luhn weighted sum of the lowest DIGITS decimal digits; odd positions doubled and folded.
  function automatic luhn_verdict_t luhn_predict(input logic [ID_W-1:0] id);
    luhn_verdict_t r;
    int unsigned   rest;
    int unsigned   total;
    int unsigned   d;
    rest  = 32'(id);
    total = 0;
    for (int pos = 0; pos < DIGITS; pos++) begin
      d    = rest % 10;
      rest = rest / 10;
      if (pos % 2 == 1) begin
        d = d * 2;
        if (d >= 10) begin
          d = d / 10 + d % 10;
        end
      end
      total += d;
    end
    r.is_valid  = (total != 0) && (total % 10 == 0);
    r.digit_sum = SUM_W'(total);
    return r;
  endfunction

  // Random digits, optionally with the check digit set so the number passes.
  function automatic logic [ID_W-1:0] make_digit_id(input bit well_formed);
    int unsigned   value;
    luhn_verdict_t partial;
    value = 0;
    for (int k = 0; k < DIGITS; k++) begin
      value = value * 10 + $urandom_range(9);
    end
    if (well_formed) begin
      value   = value - value % 10;
      partial = luhn_predict(ID_W'(value));
      value   = value + (10 - partial.digit_sum % 10) % 10;
    end
    return ID_W'(value);
  endfunction

  // Offer one beat, with occasional random idle cycles first, and wait for the handshake.
  task automatic send_id(input logic [ID_W-1:0] id);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.id_number = id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back('{id: id, verdict: luhn_predict(id)});
    n_sent++;
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_drained;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed;
    logic [ID_W-1:0] probes [20];
    probes = '{
      30'd0,           // all digits zero: sum zero, not valid
      30'd999999999,   // largest nine-digit value
      30'd1073741823,  // every input bit set, tenth digit present
      30'd1000000000,  // only the ignored tenth digit nonzero
      30'd18,          // doubled 1 plus 8 makes ten
      30'd59,          // doubled 5 folds to 1
      30'd90,          // doubled 9 folds to 9
      30'd909090909,
      30'd90909090,
      30'd123456782,   // passes
      30'd123456789,
      30'd1,
      30'd10,
      30'd100000000,   // top counted digit sits on an undoubled position
      30'd10000000,
      30'd555555555,
      30'd536870912,   // top input bit alone
      30'd999999990,
      30'd918273645,
      30'd1073741000
    };
    foreach (probes[i]) begin
      send_id(probes[i]);
    end
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while the sender keeps pushing: the row fills up.
  task automatic test_backpressure;
    quiet = 1'b1;
    @(posedge clk);
    hold_trigger++;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_id(make_digit_id(1'($urandom_range(1))));
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned     kind;
    logic [ID_W-1:0] id;
    for (int unsigned i = 0; i < count; i++) begin
      quiet = (i >= count / 3) && (i < count / 3 + 100);
      kind  = $urandom_range(99);
      if (kind < 45) begin
        id = make_digit_id(1'b1);
      end else if (kind < 75) begin
        id = ID_W'($urandom_range(999999999));
      end else if (kind < 90) begin
        id = make_digit_id(1'b0);
      end else begin
        id = ID_W'($urandom);  // full field range, tenth digit sometimes set
      end
      send_id(id);
    end
    quiet = 1'b0;
  endtask

  // Receiver: random ready, a quiet stretch, and the long hold-off on request.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_result
    pending_check_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("%0t: result beat with nothing pending: is_valid=%b digit_sum=%0d",
                   $realtime, out_ch.is_valid, out_ch.digit_sum);
        end
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (want.verdict.is_valid) begin
          n_passing++;
        end
        if (out_ch.is_valid !== want.verdict.is_valid ||
            out_ch.digit_sum !== want.verdict.digit_sum) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: id %0d: expected is_valid=%b digit_sum=%0d, got is_valid=%b digit_sum=%0d",
                     $realtime, want.id, want.verdict.is_valid, want.verdict.digit_sum,
                     out_ch.is_valid, out_ch.digit_sum);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin : watchdog
    int unsigned stall_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, pending_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.id_number = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random(RANDOM_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d identity numbers, %0d of them passing the mod-10 test,",
             n_checked, n_sent, n_passing);
    $display("with random gaps on both channels and a %0d-cycle output stall; %0d mismatches.",
             HOLD_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
